// File: hw/rtl/tccw_pkg.sv
// Package for the text console character writer.
// Holds field widths, character codes, controller states and the command and status structs.
// No dependencies.
package tccw_pkg;

  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int POS_W   = 11;
  localparam int WORD_W  = 16;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;

  localparam logic [CHAR_W-1:0] RESET_ATTR = 8'h0F;
  localparam logic [WORD_W-1:0] RESET_CELL = {RESET_ATTR, CHAR_BLANK};
  localparam int                TAB_STEP   = 8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_BLANK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic exec;
    logic copy;
    logic blank;
    logic sweep_clr;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic need_scroll;
    logic at_last_cell;
    logic at_copy_end;
  } status_t;

endpackage

// File: hw/rtl/tccw_req_if.sv
// Request channel interface of the text console character writer.
// Depends on tccw_pkg for the field widths.
interface tccw_req_if;
  import tccw_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [CHAR_W-1:0]  char_code;
  logic [INDEX_W-1:0] cell_index;

  modport source (output valid, output mode, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input mode, input char_code, input cell_index,
                output ready);
endinterface

// File: hw/rtl/tccw_rsp_if.sv
// Response channel interface of the text console character writer.
// Depends on tccw_pkg for the field widths.
interface tccw_rsp_if;
  import tccw_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic [WORD_W-1:0] cell_word;
  logic              scrolled;

  modport source (output valid, output cursor_position, output cell_word, output scrolled,
                  input ready);
  modport sink (input valid, input cursor_position, input cell_word, input scrolled,
                output ready);
endinterface

// File: hw/rtl/tccw_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/tccw_ctrl.sv
// Controller state machine of the text console character writer.
// Depends on tccw_pkg for the state type and the command and status structs.
module tccw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tccw_pkg::status_t status,
  output tccw_pkg::cmd_t    cmd
);
  import tccw_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.at_last_cell) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        priority if (status.is_read) begin
          state_next = ST_DONE;
        end else if (status.need_scroll) begin
          state_next = ST_COPY;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_COPY: begin
        if (status.at_copy_end) begin
          state_next = ST_BLANK;
        end
      end
      ST_BLANK: begin
        if (status.at_last_cell) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_wr  = 1'b1;
        cmd.sweep_clr = status.at_last_cell;
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.sweep_clr = 1'b1;
      end
      ST_COPY: begin
        cmd.copy = 1'b1;
      end
      ST_BLANK: begin
        cmd.blank = 1'b1;
      end
      ST_DONE: begin
        cmd.load_result = out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // A held result must never be overwritten before it is taken.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> (!out_valid || out_ready))
    else $error("result register overwritten while still held");

  // A new result only ever appears straight after the finishing state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the finishing state");

  // No transaction is taken while the cell store is being cleared after reset.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready)
    else $error("request accepted during the clearing pass");

endmodule

// File: hw/rtl/tccw_datapath.sv
// Datapath of the text console character writer: cursor, attribute, sweep counter,
// cell store and result registers. Depends on tccw_pkg and tccw_ram.
module tccw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tccw_pkg::cmd_t                        cmd,
  output tccw_pkg::status_t                     status,
  input  logic                                  req_mode,
  input  logic [tccw_pkg::CHAR_W-1:0]           req_char_code,
  input  logic [tccw_pkg::INDEX_W-1:0]          req_cell_index,
  input  logic                                  attr_we,
  input  logic [tccw_pkg::CHAR_W-1:0]           attr_wdata,
  output logic [tccw_pkg::POS_W-1:0]            rsp_cursor_position,
  output logic [tccw_pkg::WORD_W-1:0]           rsp_cell_word,
  output logic                                  rsp_scrolled
);
  import tccw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);

  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);
  localparam logic [COL_W:0]    COL_LIMIT = (COL_W + 1)'(COLUMNS);
  localparam logic [COL_W:0]    TAB_ADD   = (COL_W + 1)'(TAB_STEP);
  localparam logic [COL_W:0]    TAB_MASK  = ~((COL_W + 1)'(TAB_STEP - 1));
  localparam logic [ROW_W:0]    ROW_LIMIT = (ROW_W + 1)'(ROWS);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);

  logic [CHAR_W-1:0] attr;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [ADDR_W-1:0] sweep;
  logic              item_mode;
  logic [CHAR_W-1:0] item_code;
  logic              item_in_range;
  logic              scroll_flag;
  logic [WORD_W-1:0] word;

  logic [ADDR_W-1:0] pos;
  logic [COL_W:0]    col_next;
  logic [ROW_W:0]    row_next;
  logic              printable;
  logic              need_scroll;
  logic              req_in_range;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  assign pos          = ADDR_W'(cursor_row) * ROW_SPAN + ADDR_W'(cursor_col);
  assign printable    = !item_code[CHAR_W-1] && (item_code >= CHAR_BLANK);
  assign req_in_range = 32'(req_cell_index) < CELL_COUNT;

  always_comb begin
    col_next = {1'b0, cursor_col};
    row_next = {1'b0, cursor_row};
    priority if (item_code == CHAR_BS) begin
      if (cursor_col != '0) begin
        col_next = {1'b0, cursor_col} - 1'b1;
      end
    end else if (item_code == CHAR_TAB) begin
      col_next = ({1'b0, cursor_col} + TAB_ADD) & TAB_MASK;
    end else if (item_code == CHAR_CR) begin
      col_next = '0;
    end else if (item_code == CHAR_LF) begin
      col_next = '0;
      row_next = {1'b0, cursor_row} + 1'b1;
    end else if (printable) begin
      col_next = {1'b0, cursor_col} + 1'b1;
    end
    if (col_next >= COL_LIMIT) begin
      col_next = '0;
      row_next = row_next + 1'b1;
    end
  end

  assign need_scroll = row_next == ROW_LIMIT;

  assign status.is_read      = item_mode == MODE_READ;
  assign status.need_scroll  = need_scroll;
  assign status.at_last_cell = sweep == CELL_LAST;
  assign status.at_copy_end  = sweep == COPY_END;

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= RESET_ATTR;
    end else if (attr_we) begin
      attr <= attr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.sweep_clr) begin
      sweep <= '0;
    end else if (cmd.clear_wr || cmd.blank || (cmd.copy && !status.at_copy_end)) begin
      sweep <= sweep + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col  <= '0;
      cursor_row  <= '0;
      scroll_flag <= 1'b0;
    end else if (cmd.accept) begin
      scroll_flag <= 1'b0;
    end else if (cmd.exec && item_mode == MODE_PUT) begin
      cursor_col  <= col_next[COL_W-1:0];
      cursor_row  <= need_scroll ? ROW_LAST : row_next[ROW_W-1:0];
      scroll_flag <= need_scroll;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_mode     <= req_mode;
      item_code     <= req_char_code;
      item_in_range <= req_in_range;
      word          <= '0;
    end else if (cmd.exec && item_mode == MODE_READ && item_in_range) begin
      word <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      rsp_cursor_position <= POS_W'(pos);
      rsp_cell_word       <= word;
      rsp_scrolled        <= scroll_flag;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep;
    ram_wdata = RESET_CELL;
    priority if (cmd.clear_wr) begin
      ram_we = 1'b1;
    end else if (cmd.exec && item_mode == MODE_PUT && printable) begin
      ram_we    = 1'b1;
      ram_waddr = pos;
      ram_wdata = {attr, item_code};
    end else if (cmd.copy && sweep != '0) begin
      ram_we    = 1'b1;
      ram_waddr = sweep - 1'b1;
      ram_wdata = ram_rdata;
    end else if (cmd.blank) begin
      ram_we    = 1'b1;
      ram_wdata = {attr, CHAR_BLANK};
    end
  end

  assign ram_re    = (cmd.accept && req_mode == MODE_READ && req_in_range)
                   || (cmd.copy && !status.at_copy_end);
  assign ram_raddr = cmd.copy ? sweep + ROW_SPAN : ADDR_W'(req_cell_index);

  tccw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CELL_COUNT)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The cursor always points inside the screen between transactions.
  assert property (@(posedge clk) disable iff (rst)
    (32'(cursor_col) < COLUMNS) && (32'(cursor_row) < ROWS))
    else $error("cursor left the screen");

  // A scroll always leaves the cursor on the bottom row.
  assert property (@(posedge clk) disable iff (rst)
    cmd.exec && item_mode == MODE_PUT && need_scroll |=> cursor_row == ROW_LAST)
    else $error("cursor not on bottom row after scroll");

endmodule

// File: hw/rtl/text_console_char_writer.sv
// Top level of the text console character writer.
// Depends on tccw_pkg, tccw_req_if, tccw_rsp_if, tccw_ctrl and tccw_datapath.
//
//   Channel      Kind             Carries
//   req          valid/ready in   mode, char_code, cell_index
//   rsp          valid/ready out  cursor_position, cell_word, scrolled
//   attr_we/wd   write only       text attribute byte
//
// After reset a clearing pass writes all COLUMNS*ROWS cells, one cell per cycle; no request
// is taken during it.
// A read or a put without scroll goes through accept, execute and load of the result register.
// A scroll adds a copy pass that moves rows 1 to ROWS-1 up one row and a blanking pass over
// the bottom row, cell by cell since the cell RAM has a single write port.
// A new request is taken while the previous result waits in the result register.
module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  tccw_req_if.sink                    req,
  tccw_rsp_if.source                  rsp,
  input  logic                        attr_we,
  input  logic [tccw_pkg::CHAR_W-1:0] attr_wdata
);
  import tccw_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

  tccw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tccw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .req_mode            (req.mode),
    .req_char_code       (req.char_code),
    .req_cell_index      (req.cell_index),
    .attr_we             (attr_we),
    .attr_wdata          (attr_wdata),
    .rsp_cursor_position (rsp.cursor_position),
    .rsp_cell_word       (rsp.cell_word),
    .rsp_scrolled        (rsp.scrolled)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_console_char_writer: random puts and reads on the request
// interface, every response predicted by a cell-accurate console model in a scoreboard class.
// Depends on tccw_pkg, tccw_req_if, tccw_rsp_if and the text_console_char_writer RTL.
module tb;
  import tccw_pkg::*;

  localparam int COLUMNS         = 80;
  localparam int ROWS            = 25;
  localparam int CELLS           = COLUMNS * ROWS;
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 370;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int CYCLE_LIMIT     = 25000000;

  localparam logic [CHAR_W-1:0]  CHAR_NUL        = 8'h00;
  localparam logic [CHAR_W-1:0]  CHAR_LOW_LAST   = 8'h1F;
  localparam logic [CHAR_W-1:0]  CHAR_PRINT_LAST = 8'h7F;
  localparam logic [CHAR_W-1:0]  CHAR_HIGH_FIRST = 8'h80;
  localparam logic [CHAR_W-1:0]  CHAR_HIGH_LAST  = 8'hFF;
  localparam logic [CHAR_W-1:0]  CHAR_UPPER_A    = 8'h41;
  localparam logic [INDEX_W-1:0] INDEX_MAX       = '1;

  class console_scoreboard;
    typedef struct packed {
      logic [POS_W-1:0]  cursor_position;
      logic [WORD_W-1:0] cell_word;
      logic              scrolled;
    } console_rsp_t;

    logic [WORD_W-1:0] screen [CELLS];
    logic [CHAR_W-1:0] attribute;
    int                column;
    int                row;
    int                errors;
    console_rsp_t      awaited_rsp [$];

    function new();
      foreach (screen[i]) screen[i] = RESET_CELL;
      attribute = RESET_ATTR;
      column    = 0;
      row       = 0;
      errors    = 0;
    endfunction

    function void note_request(logic mode, logic [CHAR_W-1:0] code,
                               logic [INDEX_W-1:0] index);
      console_rsp_t outcome;
      int           i;
      outcome = '0;
      if (mode == MODE_PUT) begin
        if (code == CHAR_BS) begin
          if (column != 0) column--;
        end else if (code == CHAR_TAB) begin
          column = (column + TAB_STEP) & ~(TAB_STEP - 1);
        end else if (code == CHAR_CR) begin
          column = 0;
        end else if (code == CHAR_LF) begin
          column = 0;
          row++;
        end else if (code >= CHAR_BLANK && code <= CHAR_PRINT_LAST) begin
          if (row * COLUMNS + column < CELLS) screen[row * COLUMNS + column] = {attribute, code};
          column++;
        end
        if (column >= COLUMNS) begin
          column = 0;
          row++;
        end
        if (row >= ROWS) begin
          for (i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen[i] = {attribute, CHAR_BLANK};
          row = ROWS - 1;
          outcome.scrolled = 1'b1;
        end
      end else if (index < CELLS) begin
        outcome.cell_word = screen[index];
      end
      outcome.cursor_position = POS_W'(row * COLUMNS + column);
      awaited_rsp.push_back(outcome);
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [POS_W-1:0] pos, logic [WORD_W-1:0] word, logic scr);
      console_rsp_t exp;
      if (awaited_rsp.size() == 0) begin
        report_mismatch($sformatf("response with nothing awaited: cursor %0d word %h", pos, word));
      end else begin
        exp = awaited_rsp.pop_front();
        if (pos !== exp.cursor_position)
          report_mismatch($sformatf("cursor_position expected %0d got %0d",
                                    exp.cursor_position, pos));
        if (word !== exp.cell_word)
          report_mismatch($sformatf("cell_word expected %h got %h", exp.cell_word, word));
        if (scr !== exp.scrolled)
          report_mismatch($sformatf("scrolled expected %b got %b", exp.scrolled, scr));
      end
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              attr_we;
  logic [CHAR_W-1:0] attr_wdata;
  console_scoreboard sb;
  int                cycle_count = 0;
  int                items_sent  = 0;
  bit                hold_request = 1'b0;
  bit                no_idle      = 1'b0;

  tccw_req_if req_if ();
  tccw_rsp_if rsp_if ();

  text_console_char_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .attr_we    (attr_we),
    .attr_wdata (attr_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CHAR_W-1:0] printable();
    return CHAR_W'($urandom_range(CHAR_BLANK, CHAR_PRINT_LAST));
  endfunction

  task automatic send_item(input logic mode, input logic [CHAR_W-1:0] code,
                           input logic [INDEX_W-1:0] index, input int gap);
    req_if.valid      <= 1'b1;
    req_if.mode       <= mode;
    req_if.char_code  <= code;
    req_if.cell_index <= index;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(mode, code, index);
    if (mode == MODE_READ || code inside {CHAR_BS, CHAR_TAB, CHAR_CR, CHAR_LF} ||
        (code >= CHAR_BLANK && code <= CHAR_PRINT_LAST))
      items_sent++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] code);
    send_item(MODE_PUT, code, INDEX_W'($urandom_range(0, INDEX_MAX)), pick_gap());
  endtask

  task automatic read_cell(input int index);
    send_item(MODE_READ, CHAR_W'($urandom_range(0, CHAR_HIGH_LAST)), INDEX_W'(index), pick_gap());
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [CHAR_W-1:0] value);
    attr_we    <= 1'b1;
    attr_wdata <= value;
    @(posedge clk);
    attr_we <= 1'b0;
    sb.attribute = value;
  endtask

  task automatic run_directed();
    read_cell(0);
    read_cell(CELLS - 1);
    read_cell(CELLS);
    read_cell(INDEX_MAX);
    put_char(CHAR_UPPER_A);
    put_char(CHAR_PRINT_LAST);
    put_char(CHAR_BLANK);
    repeat (4) put_char(CHAR_BS);
    put_char(CHAR_TAB);
    put_char(CHAR_NUL);
    put_char(CHAR_LOW_LAST);
    put_char(CHAR_HIGH_FIRST);
    put_char(CHAR_HIGH_LAST);
    put_char(CHAR_CR);
    put_char(CHAR_LF);
    read_cell(0);
    read_cell(1);
    read_cell(2);
  endtask

  task automatic run_sequence();
    int                kind;
    int                count;
    int                cursor;
    int                pick;
    logic [CHAR_W-1:0] code;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      count = $urandom_range(1, 90);
      repeat (count) put_char(printable());
      if ($urandom_range(0, 9) < 7) begin
        put_char(CHAR_CR);
        put_char(CHAR_LF);
      end
    end else if (kind < 45) begin
      count = $urandom_range(1, 12);
      repeat (count) begin
        put_char(CHAR_TAB);
        if ($urandom_range(0, 2) == 0) put_char(printable());
      end
    end else if (kind < 55) begin
      count = $urandom_range(1, 8);
      repeat (count) put_char(CHAR_BS);
      put_char(printable());
    end else if (kind < 62) begin
      if ($urandom_range(0, 1) == 0) put_char(CHAR_CR);
      count = $urandom_range(1, 4);
      repeat (count) put_char(CHAR_LF);
    end else if (kind < 80) begin
      count = $urandom_range(1, 6);
      repeat (count) begin
        cursor = sb.row * COLUMNS + sb.column;
        pick   = $urandom_range(0, 3);
        if (pick == 0) begin
          read_cell($urandom_range(0, INDEX_MAX));
        end else if (pick == 1) begin
          read_cell(cursor - $urandom_range(0, (cursor < 160) ? cursor : 160));
        end else if (pick == 2) begin
          read_cell(cursor + $urandom_range(0, 8));
        end else begin
          read_cell((ROWS - 1) * COLUMNS + $urandom_range(0, COLUMNS - 1));
        end
      end
    end else if (kind < 92) begin
      count = $urandom_range(1, 4);
      repeat (count)
        send_item(logic'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, CHAR_HIGH_LAST)),
                  INDEX_W'($urandom_range(0, INDEX_MAX)), pick_gap());
    end else begin
      count = $urandom_range(1, 3);
      repeat (count) begin
        if ($urandom_range(0, 1) == 0) begin
          code = CHAR_W'($urandom_range(CHAR_HIGH_FIRST, CHAR_HIGH_LAST));
        end else begin
          do code = CHAR_W'($urandom_range(CHAR_NUL, CHAR_LOW_LAST));
          while (code inside {CHAR_BS, CHAR_TAB, CHAR_CR, CHAR_LF});
        end
        put_char(code);
      end
    end
  endtask

  task automatic run_random(input int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) run_sequence();
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.cursor_position, rsp_if.cell_word, rsp_if.scrolled);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    int phase;
    sb = new();
    rst               <= 1'b1;
    attr_we           <= 1'b0;
    attr_wdata        <= RESET_ATTR;
    req_if.valid      <= 1'b0;
    req_if.mode       <= MODE_PUT;
    req_if.char_code  <= CHAR_BLANK;
    req_if.cell_index <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        run_directed();
      end else begin
        wait_drained();
        if (phase == 1) write_attribute(CHAR_HIGH_LAST);
        else if (phase == 2) write_attribute(CHAR_NUL);
        else write_attribute(CHAR_W'($urandom_range(0, CHAR_HIGH_LAST)));
      end
      // The receiver holds off while requests keep coming, so the block backs up.
      if (phase == 1) begin
        hold_request = 1'b1;
        repeat (12)
          send_item(MODE_READ, CHAR_NUL, INDEX_W'($urandom_range(0, INDEX_MAX)), 0);
      end
      no_idle = (phase == 2);
      run_random(ITEMS_PER_PHASE / 2);
      if (phase == 3) wait_drained();
      run_random(ITEMS_PER_PHASE / 2);
      no_idle = 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
